/* sv/aar_pkg.sv */
// Shared types, constants and fixed-point helpers for the axis-angle rotation block.
package aar_pkg;

  localparam int FRAC_BITS = 14;
  localparam int VAL_W     = 20;
  localparam int ENT_W     = 16;
  localparam int IN_W      = 16;
  localparam int SQ_STEPS  = 32;
  localparam int DIV_STEPS = 16;
  localparam int SER_STEPS = 7;

  // quarter-angle conversion: Q3.13 / 4 -> FRAC_BITS fraction bits
  localparam int QSH   = 15 - FRAC_BITS;
  localparam int QHALF = 1 << (QSH - 1);

  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic signed [ENT_W-1:0] ent_t;
  typedef logic signed [IN_W-1:0]  in_t;

  localparam val_t ONE     = val_t'(1 << FRAC_BITS);
  localparam val_t ENT_MAX = val_t'((1 << (ENT_W - 1)) - 1);
  localparam val_t ENT_MIN = -val_t'(1 << (ENT_W - 1));

  typedef struct packed {
    in_t  x;
    in_t  y;
    in_t  z;
    in_t  ang;
    logic zero;
  } side_t;

  typedef struct packed {
    logic [32:0] rem;
    logic [31:0] root;
    logic [63:0] rad;
    side_t       side;
  } sq_word_t;

  typedef struct packed {
    logic [31:0] part;
    logic [15:0] low;
    logic [15:0] quo;
    logic        neg;
  } div_lane_t;

  typedef struct packed {
    logic [31:0]     s;
    div_lane_t [2:0] lane;
    in_t             ang;
    logic            zero;
  } div_word_t;

  typedef struct packed {
    val_t q;
    val_t q2;
    val_t ps;
    val_t pc;
    val_t u;
    val_t v;
    val_t w;
    logic zero;
  } ser_word_t;

  // series divisors per step: cosine (2k-1)(2k) for k=7..1, sine (2k)(2k+1) for k=6..1.
  // Sine step 0 has a zero reciprocal, so the term passes ONE through.
  localparam logic [31:0] RECIP_C [SER_STEPS] = '{
    32'((64'd4294967296 + 64'd181) / 64'd182),
    32'((64'd4294967296 + 64'd131) / 64'd132),
    32'((64'd4294967296 + 64'd89)  / 64'd90),
    32'((64'd4294967296 + 64'd55)  / 64'd56),
    32'((64'd4294967296 + 64'd29)  / 64'd30),
    32'((64'd4294967296 + 64'd11)  / 64'd12),
    32'((64'd4294967296 + 64'd1)   / 64'd2)
  };
  localparam logic [7:0] HALF_C [SER_STEPS] = '{
    8'(182 / 2), 8'(132 / 2), 8'(90 / 2), 8'(56 / 2), 8'(30 / 2), 8'(12 / 2), 8'(2 / 2)
  };
  localparam logic [31:0] RECIP_S [SER_STEPS] = '{
    32'd0,
    32'((64'd4294967296 + 64'd155) / 64'd156),
    32'((64'd4294967296 + 64'd109) / 64'd110),
    32'((64'd4294967296 + 64'd71)  / 64'd72),
    32'((64'd4294967296 + 64'd41)  / 64'd42),
    32'((64'd4294967296 + 64'd19)  / 64'd20),
    32'((64'd4294967296 + 64'd5)   / 64'd6)
  };
  localparam logic [7:0] HALF_S [SER_STEPS] = '{
    8'd0, 8'(156 / 2), 8'(110 / 2), 8'(72 / 2), 8'(42 / 2), 8'(20 / 2), 8'(6 / 2)
  };

  function automatic logic [VAL_W-1:0] mag(val_t a);
    return a[VAL_W-1] ? VAL_W'(-a) : VAL_W'(a);
  endfunction

  // |a|*|b| rounded half away from zero, sign applied after
  function automatic val_t fx_mul(val_t a, val_t b);
    logic [2*VAL_W-1:0] p;
    logic [2*VAL_W-1:0] r;
    val_t m;
    p = (2*VAL_W)'(mag(a)) * (2*VAL_W)'(mag(b));
    r = (p + (2*VAL_W)'(1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    m = val_t'(r[VAL_W-1:0]);
    return (a[VAL_W-1] ^ b[VAL_W-1]) ? -m : m;
  endfunction

  function automatic ent_t clamp_entry(val_t v);
    val_t t;
    t = v;
    if (t > ONE) t = ONE;
    if (t < -ONE) t = -ONE;
    if (t > ENT_MAX) t = ENT_MAX;
    if (t < ENT_MIN) t = ENT_MIN;
    return ent_t'(t);
  endfunction

endpackage

/* sv/aar_sqrt_cell.sv */
// One root bit of the bit-serial integer square root chain.
module aar_sqrt_cell import aar_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     en,
  input  logic     in_valid,
  input  sq_word_t in_w,
  output logic     out_valid,
  output sq_word_t out_w
);

  logic [34:0] cur;
  logic [33:0] trial;
  logic        ge;
  sq_word_t    w_next;

  always_comb begin
    cur    = {in_w.rem, in_w.rad[63:62]};
    trial  = {in_w.root, 2'b01};
    ge     = cur >= {1'b0, trial};
    w_next = in_w;
    w_next.rad = {in_w.rad[61:0], 2'b00};
    if (ge) begin
      w_next.rem  = 33'(cur - {1'b0, trial});
      w_next.root = {in_w.root[30:0], 1'b1};
    end else begin
      w_next.rem  = cur[32:0];
      w_next.root = {in_w.root[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_w <= w_next;
    end
  end

endmodule

/* sv/aar_div_cell.sv */
// One quotient bit of the restoring division, three axis lanes side by side.
module aar_div_cell import aar_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  logic      in_valid,
  input  div_word_t in_w,
  output logic      out_valid,
  output div_word_t out_w
);

  logic [32:0] cur;
  logic        ge;
  div_word_t   w_next;

  always_comb begin
    w_next = in_w;
    cur    = '0;
    ge     = 1'b0;
    for (int i = 0; i < 3; i++) begin
      cur = {in_w.lane[i].part, in_w.lane[i].low[15]};
      ge  = cur >= {1'b0, in_w.s};
      w_next.lane[i].part = ge ? 32'(cur - {1'b0, in_w.s}) : cur[31:0];
      w_next.lane[i].low  = {in_w.lane[i].low[14:0], 1'b0};
      w_next.lane[i].quo  = {in_w.lane[i].quo[14:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_w <= w_next;
    end
  end

endmodule

/* sv/aar_series_cell.sv */
// One nested step of the sine and cosine series: p = ONE - rdiv(q2*p, k), two stages.
module aar_series_cell import aar_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  ser_word_t   in_w,
  input  logic [31:0] recip_s,
  input  logic [7:0]  half_s,
  input  logic [31:0] recip_c,
  input  logic [7:0]  half_c,
  output logic        out_valid,
  output ser_word_t   out_w
);

  // rounded divide by a constant through its 32-bit reciprocal (exact for these ranges)
  function automatic val_t rdiv(val_t n, logic [31:0] r, logic [7:0] h);
    logic [VAL_W:0]    m;
    logic [VAL_W+32:0] p;
    val_t              q;
    m = (VAL_W+1)'(mag(n)) + (VAL_W+1)'(h);
    p = (VAL_W+33)'(m) * (VAL_W+33)'(r);
    q = val_t'(p[VAL_W+31:32]);
    return n[VAL_W-1] ? -q : q;
  endfunction

  logic      mid_valid;
  ser_word_t mid_w;
  val_t      mid_ns;
  val_t      mid_nc;
  ser_word_t w_next;

  always_comb begin
    w_next    = mid_w;
    w_next.ps = ONE - rdiv(mid_ns, recip_s, half_s);
    w_next.pc = ONE - rdiv(mid_nc, recip_c, half_c);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      mid_valid <= in_valid;
      out_valid <= mid_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mid_w  <= in_w;
      mid_ns <= fx_mul(in_w.q2, in_w.ps);
      mid_nc <= fx_mul(in_w.q2, in_w.pc);
      out_w  <= w_next;
    end
  end

endmodule

/* sv/aar_compose.sv */
// Sine finish, two angle doublings and the nine matrix entries, ending in the output register.
module aar_compose import aar_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  ser_word_t      in_w,
  output logic           out_valid,
  output ent_t [8:0]     ent,
  output logic           zero
);

  logic a_valid, b_valid, c_valid, d_valid;
  val_t a_sn, a_cs, a_u, a_v, a_w;
  logic a_zero;
  val_t b_sn, b_cs, b_uu, b_vv, b_ww, b_uv, b_uw, b_vw, b_u, b_v, b_w;
  logic b_zero;
  val_t c_sn, c_cs, c_uu, c_vv, c_ww, c_uv, c_uw, c_vw, c_u, c_v, c_w;
  logic c_zero;
  val_t d_uu, d_vv, d_ww, d_t0, d_t4, d_t8, d_uvc, d_uwc, d_vwc, d_ws, d_vs, d_us;
  logic d_zero;
  val_t omc;
  val_t raw [9];

  assign omc = ONE - c_cs;

  always_comb begin
    raw[0] = d_uu + d_t0;
    raw[1] = d_uvc + d_ws;
    raw[2] = d_uwc - d_vs;
    raw[3] = d_uvc - d_ws;
    raw[4] = d_vv + d_t4;
    raw[5] = d_vwc + d_us;
    raw[6] = d_uwc + d_vs;
    raw[7] = d_vwc - d_us;
    raw[8] = d_ww + d_t8;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      c_valid   <= 1'b0;
      d_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      a_valid   <= in_valid;
      b_valid   <= a_valid;
      c_valid   <= b_valid;
      d_valid   <= c_valid;
      out_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // quarter-angle sine
      a_sn   <= fx_mul(in_w.q, in_w.ps);
      a_cs   <= in_w.pc;
      a_u    <= in_w.u;
      a_v    <= in_w.v;
      a_w    <= in_w.w;
      a_zero <= in_w.zero;
      // first doubling, axis products
      b_sn   <= val_t'(fx_mul(a_sn, a_cs) <<< 1);
      b_cs   <= ONE - val_t'(fx_mul(a_sn, a_sn) <<< 1);
      b_uu   <= fx_mul(a_u, a_u);
      b_vv   <= fx_mul(a_v, a_v);
      b_ww   <= fx_mul(a_w, a_w);
      b_uv   <= fx_mul(a_u, a_v);
      b_uw   <= fx_mul(a_u, a_w);
      b_vw   <= fx_mul(a_v, a_w);
      b_u    <= a_u;
      b_v    <= a_v;
      b_w    <= a_w;
      b_zero <= a_zero;
      // second doubling
      c_sn   <= val_t'(fx_mul(b_sn, b_cs) <<< 1);
      c_cs   <= ONE - val_t'(fx_mul(b_sn, b_sn) <<< 1);
      c_uu   <= b_uu;
      c_vv   <= b_vv;
      c_ww   <= b_ww;
      c_uv   <= b_uv;
      c_uw   <= b_uw;
      c_vw   <= b_vw;
      c_u    <= b_u;
      c_v    <= b_v;
      c_w    <= b_w;
      c_zero <= b_zero;
      // Rodrigues terms
      d_uu   <= c_uu;
      d_vv   <= c_vv;
      d_ww   <= c_ww;
      d_t0   <= fx_mul(c_vv + c_ww, c_cs);
      d_t4   <= fx_mul(c_uu + c_ww, c_cs);
      d_t8   <= fx_mul(c_uu + c_vv, c_cs);
      d_uvc  <= fx_mul(c_uv, omc);
      d_uwc  <= fx_mul(c_uw, omc);
      d_vwc  <= fx_mul(c_vw, omc);
      d_ws   <= fx_mul(c_w, c_sn);
      d_vs   <= fx_mul(c_v, c_sn);
      d_us   <= fx_mul(c_u, c_sn);
      d_zero <= c_zero;
      // output register
      zero   <= d_zero;
      for (int i = 0; i < 9; i++) begin
        if (d_zero) begin
          ent[i] <= (i % 4 == 0) ? ent_t'(ONE) : '0;
        end else begin
          ent[i] <= clamp_entry(raw[i]);
        end
      end
    end
  end

endmodule

/* sv/axis_angle_to_rotation_matrix.sv */
// Axis-angle to 3x3 rotation matrix: top level, front stages and cell chains.
//
// Input channel: item_valid / item_stall carry one word of axis_x, axis_y, axis_z
// (signed, any scale) and angle (signed Q3.13 radians). A word is taken at a rising
// edge with item_valid high and item_stall low.
// Output channel: result_valid / result_stall carry m00..m22 (signed Q1.14, clamped
// to +-1.0) and zero_axis. An all-zero axis gives the identity with zero_axis set.
// Pipeline: 70 register stages:
//   1 squares, 32 root cells, 1 division setup, 16 divider cells,
//   1 quarter angle, 7 series cells of 2 stages, 5 compose stages incl. output reg.
// Throughput: one word per cycle while no result is stalled; all cells advance together on one enable.
// Depth is set by the root chain (one root bit per cell) and the divider chain
// (one quotient bit per cell for all three axis lanes).
// Stall: the chain moves whenever the output register is empty or being read, so
// the block keeps taking words while the receiver takes results. When the
// receiver stalls a valid result, the whole chain holds and item_stall rises the
// same cycle; the result word stays unchanged.
// Reset (rst, synchronous): clears all stage valid bits; nothing is in flight after.
module axis_angle_to_rotation_matrix import aar_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic signed [15:0] axis_x,
  input  logic signed [15:0] axis_y,
  input  logic signed [15:0] axis_z,
  input  logic signed [15:0] angle,
  output logic        result_valid,
  input  logic        result_stall,
  output logic signed [15:0] m00,
  output logic signed [15:0] m01,
  output logic signed [15:0] m02,
  output logic signed [15:0] m10,
  output logic signed [15:0] m11,
  output logic signed [15:0] m12,
  output logic signed [15:0] m20,
  output logic signed [15:0] m21,
  output logic signed [15:0] m22,
  output logic        zero_axis
);

  // global advance: output slot free or being emptied
  logic adv;
  assign adv        = !result_valid || !result_stall;
  assign item_stall = !adv;

  // ---------------- squared norm ----------------
  logic signed [31:0] xx, yy, zz;
  logic [31:0]        n2;
  assign xx = axis_x * axis_x;
  assign yy = axis_y * axis_y;
  assign zz = axis_z * axis_z;
  assign n2 = $unsigned(xx) + $unsigned(yy) + $unsigned(zz);

  logic     sq0_v;
  sq_word_t sq0_w;
  logic     sq_v [SQ_STEPS+1];
  sq_word_t sq_w [SQ_STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq0_v <= 1'b0;
    end else if (adv) begin
      sq0_v <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq0_w.rem       <= '0;
      sq0_w.root      <= '0;
      sq0_w.rad       <= {n2, 32'd0};   // root of n2 * 2^32
      sq0_w.side.x    <= axis_x;
      sq0_w.side.y    <= axis_y;
      sq0_w.side.z    <= axis_z;
      sq0_w.side.ang  <= angle;
      sq0_w.side.zero <= (axis_x == '0) && (axis_y == '0) && (axis_z == '0);
    end
  end

  assign sq_v[0] = sq0_v;
  assign sq_w[0] = sq0_w;

  for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sq
    aar_sqrt_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (adv),
      .in_valid  (sq_v[g]),
      .in_w      (sq_w[g]),
      .out_valid (sq_v[g+1]),
      .out_w     (sq_w[g+1])
    );
  end

  // ---------------- division setup ----------------
  // numerator |c| * 2^30 + s/2; top bits seed the partial remainder
  function automatic div_lane_t lane_init(in_t c, logic [31:0] s);
    logic [15:0] a;
    logic [45:0] num;
    div_lane_t   l;
    a      = c[15] ? 16'(-c) : 16'(c);
    num    = {a, 30'd0} + 46'(s >> 1);
    l.part = 32'(num[45:16]);
    l.low  = num[15:0];
    l.quo  = '0;
    l.neg  = c[15];
    return l;
  endfunction

  logic      dv0_v;
  div_word_t dv0_w;
  logic      dv_v [DIV_STEPS+1];
  div_word_t dv_w [DIV_STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv0_v <= 1'b0;
    end else if (adv) begin
      dv0_v <= sq_v[SQ_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv0_w.s       <= sq_w[SQ_STEPS].root;
      dv0_w.lane[0] <= lane_init(sq_w[SQ_STEPS].side.x, sq_w[SQ_STEPS].root);
      dv0_w.lane[1] <= lane_init(sq_w[SQ_STEPS].side.y, sq_w[SQ_STEPS].root);
      dv0_w.lane[2] <= lane_init(sq_w[SQ_STEPS].side.z, sq_w[SQ_STEPS].root);
      dv0_w.ang     <= sq_w[SQ_STEPS].side.ang;
      dv0_w.zero    <= sq_w[SQ_STEPS].side.zero;
    end
  end

  assign dv_v[0] = dv0_v;
  assign dv_w[0] = dv0_w;

  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_dv
    aar_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (adv),
      .in_valid  (dv_v[g]),
      .in_w      (dv_w[g]),
      .out_valid (dv_v[g+1]),
      .out_w     (dv_w[g+1])
    );
  end

  // ---------------- unit axis and quarter angle ----------------
  function automatic val_t unit_of(div_lane_t l);
    val_t m;
    m = val_t'(l.quo);
    return l.neg ? -m : m;
  endfunction

  div_word_t   dv_last;
  logic [15:0] ang_mag;
  logic [16:0] q_mag;
  val_t        q_c;

  assign dv_last = dv_w[DIV_STEPS];
  assign ang_mag = dv_last.ang[15] ? 16'(-dv_last.ang) : 16'(dv_last.ang);
  assign q_mag   = (17'(ang_mag) + 17'(QHALF)) >> QSH;
  assign q_c     = dv_last.ang[15] ? -val_t'(q_mag) : val_t'(q_mag);

  logic      sr0_v;
  ser_word_t sr0_w;
  logic      sr_v [SER_STEPS+1];
  ser_word_t sr_w [SER_STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      sr0_v <= 1'b0;
    end else if (adv) begin
      sr0_v <= dv_v[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sr0_w.q    <= q_c;
      sr0_w.q2   <= fx_mul(q_c, q_c);
      sr0_w.ps   <= ONE;
      sr0_w.pc   <= ONE;
      sr0_w.u    <= unit_of(dv_last.lane[0]);
      sr0_w.v    <= unit_of(dv_last.lane[1]);
      sr0_w.w    <= unit_of(dv_last.lane[2]);
      sr0_w.zero <= dv_last.zero;
    end
  end

  assign sr_v[0] = sr0_v;
  assign sr_w[0] = sr0_w;

  for (genvar g = 0; g < SER_STEPS; g++) begin : g_sr
    aar_series_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (adv),
      .in_valid  (sr_v[g]),
      .in_w      (sr_w[g]),
      .recip_s   (RECIP_S[g]),
      .half_s    (HALF_S[g]),
      .recip_c   (RECIP_C[g]),
      .half_c    (HALF_C[g]),
      .out_valid (sr_v[g+1]),
      .out_w     (sr_w[g+1])
    );
  end

  // ---------------- doubling, matrix, output register ----------------
  ent_t [8:0] ent;

  aar_compose u_compose (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (sr_v[SER_STEPS]),
    .in_w      (sr_w[SER_STEPS]),
    .out_valid (result_valid),
    .ent       (ent),
    .zero      (zero_axis)
  );

  assign m00 = ent[0];
  assign m01 = ent[1];
  assign m02 = ent[2];
  assign m10 = ent[3];
  assign m11 = ent[4];
  assign m12 = ent[5];
  assign m20 = ent[6];
  assign m21 = ent[7];
  assign m22 = ent[8];

endmodule

/* sv/aar_checker.sv */
// Port-level checks for the axis-angle rotation block, bound to the top level.
module aar_checker import aar_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_stall,
  input logic              result_valid,
  input logic              result_stall,
  input logic signed [15:0] m00,
  input logic signed [15:0] m01,
  input logic signed [15:0] m11,
  input logic signed [15:0] m22,
  input logic              zero_axis
);

  // a stalled result holds: m00, m01 and zero_axis stay stable
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(m00) && $stable(m01)
      && $stable(zero_axis))
    else $error("stalled result word changed");

  // input backpressure only comes from a stalled result
  a_bp: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> result_valid && result_stall)
    else $error("input stalled without output backpressure");

  // zero axis gives identity (m00, m11, m22 and m01 checked)
  a_ident: assert property (@(posedge clk) disable iff (rst)
    result_valid && zero_axis |-> m00 == ent_t'(ONE) && m11 == ent_t'(ONE)
      && m22 == ent_t'(ONE) && m01 == '0)
    else $error("zero axis without identity");

  // entries m00 and m01 stay within +-1.0
  a_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> m00 <= ent_t'(ONE) && m00 >= -ent_t'(ONE)
      && m01 <= ent_t'(ONE) && m01 >= -ent_t'(ONE))
    else $error("matrix entry out of range");

  // input valid is watched so a stuck-high source is visible in waves
  logic item_seen;
  assign item_seen = item_valid;

  a_idle_in: assert property (@(posedge clk) disable iff (rst)
    !item_seen |-> !item_stall || result_valid)
    else $error("input stall with no result pending");

endmodule

bind axis_angle_to_rotation_matrix aar_checker u_aar_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .m00          (m00),
  .m01          (m01),
  .m11          (m11),
  .m22          (m22),
  .zero_axis    (zero_axis)
);

/* tb/sv/axis_angle_to_rotation_matrix_tb.sv */
// Testbench for the axis-angle to rotation matrix block: predictor, stimulus, checker.
module axis_angle_to_rotation_matrix_tb;
  import aar_pkg::*;

  localparam int FB = 14;
  localparam longint ONE_L = 64'sd1 << FB;
  localparam int LATENCY = 70;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct {
    logic signed [15:0] m [9];
    logic               zero;
  } matrix_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  logic signed [15:0] axis_x = '0, axis_y = '0, axis_z = '0, angle = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
  logic zero_axis;

  matrix_t pending_matrices [$];
  int     mismatch_count = 0;
  longint cycle_count = 0;
  bit     stall_bursts = 1'b0;   // random receiver stalls enabled
  bit     send_gaps = 1'b0;      // random sender gaps enabled
  int     long_holdoff = 0;      // forced receiver stall, in cycles

  always #5 clk = ~clk;

  axis_angle_to_rotation_matrix i_dut (.*);

  // ---- fixed-point predictor ----
  function automatic longint mag_of(longint a);
    return a < 0 ? -a : a;
  endfunction

  function automatic longint rmul(longint a, longint b);
    longint m;
    m = (mag_of(a) * mag_of(b) + (64'sd1 << (FB - 1))) >>> FB;
    return ((a < 0) != (b < 0)) ? -m : m;
  endfunction

  function automatic longint rdiv(longint n, longint d);
    longint m;
    m = (mag_of(n) + d / 2) / d;
    return n < 0 ? -m : m;
  endfunction

  function automatic longint int_sqrt(logic [63:0] n);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return longint'(r);
  endfunction

  function automatic logic signed [15:0] sat_entry(longint v);
    if (v > ONE_L) v = ONE_L;
    if (v < -ONE_L) v = -ONE_L;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  function automatic matrix_t rotation_of(longint x, longint y, longint z, longint ang);
    matrix_t r;
    longint e [9];
    longint s, u, v, w, q, q2, ps, pc, sn, cs, ns, nc, omc;
    longint uu, vv, ww, uv, uw, vw, ws, vs, us, uvc, uwc, vwc;
    logic [63:0] n2;
    if (x == 0 && y == 0 && z == 0) begin
      for (int i = 0; i < 9; i++) r.m[i] = sat_entry(i % 4 == 0 ? ONE_L : 0);
      r.zero = 1'b1;
      return r;
    end
    n2 = 64'(x * x + y * y + z * z);
    s = int_sqrt(n2 << 32);
    u = rdiv(x <<< (FB + 16), s);
    v = rdiv(y <<< (FB + 16), s);
    w = rdiv(z <<< (FB + 16), s);
    q = rdiv(ang, 64'sd1 << (15 - FB));
    q2 = rmul(q, q);
    ps = ONE_L;
    pc = ONE_L;
    for (int k = 6; k >= 1; k--) ps = ONE_L - rdiv(rmul(q2, ps), (2*k) * (2*k + 1));
    for (int k = 7; k >= 1; k--) pc = ONE_L - rdiv(rmul(q2, pc), (2*k - 1) * (2*k));
    sn = rmul(q, ps);
    cs = pc;
    for (int k = 0; k < 2; k++) begin
      ns = 2 * rmul(sn, cs);
      nc = ONE_L - 2 * rmul(sn, sn);
      sn = ns;
      cs = nc;
    end
    omc = ONE_L - cs;
    uu = rmul(u, u); vv = rmul(v, v); ww = rmul(w, w);
    uv = rmul(u, v); uw = rmul(u, w); vw = rmul(v, w);
    ws = rmul(w, sn); vs = rmul(v, sn); us = rmul(u, sn);
    uvc = rmul(uv, omc); uwc = rmul(uw, omc); vwc = rmul(vw, omc);
    e[0] = uu + rmul(vv + ww, cs);
    e[1] = uvc + ws;
    e[2] = uwc - vs;
    e[3] = uvc - ws;
    e[4] = vv + rmul(uu + ww, cs);
    e[5] = vwc + us;
    e[6] = uwc + vs;
    e[7] = vwc - us;
    e[8] = ww + rmul(uu + vv, cs);
    for (int i = 0; i < 9; i++) r.m[i] = sat_entry(e[i]);
    r.zero = 1'b0;
    return r;
  endfunction

  // ---- mismatch reporting ----
  task automatic report_mismatch(string what, longint got, longint want);
    mismatch_count++;
    if (mismatch_count <= 40)
      $display("MISMATCH %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
  endtask

  // ---- cycle limit ----
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("axis_angle_to_rotation_matrix_tb NOT OK");
      $finish;
    end
  end

  // ---- receiver: random stall bursts, plus an optional long hold-off ----
  initial begin : receiver
    int n;
    forever begin
      @(posedge clk);
      if (long_holdoff > 0) begin
        result_stall <= 1'b1;
        repeat (long_holdoff) @(posedge clk);
        long_holdoff = 0;
        result_stall <= 1'b0;
      end else if (stall_bursts && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 18);
        result_stall <= 1'b1;
        repeat (n - 1) @(posedge clk);
        if (long_holdoff == 0) result_stall <= 1'b0;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  // ---- result checker: compare each accepted word with the oldest prediction ----
  always @(posedge clk) begin
    matrix_t want;
    logic signed [15:0] got [9];
    if (!rst && result_valid && !result_stall) begin
      got = '{m00, m01, m02, m10, m11, m12, m20, m21, m22};
      if (pending_matrices.size() == 0) begin
        report_mismatch("unexpected result word", 1, 0);
      end else begin
        want = pending_matrices.pop_front();
        for (int i = 0; i < 9; i++)
          if (got[i] !== want.m[i])
            report_mismatch($sformatf("m%0d%0d", i / 3, i % 3), got[i], want.m[i]);
        if (zero_axis !== want.zero) report_mismatch("zero_axis", zero_axis, want.zero);
      end
    end
  end

  // ---- sender: drive one word and wait for acceptance ----
  task automatic send_word(logic signed [15:0] x, logic signed [15:0] y,
                           logic signed [15:0] z, logic signed [15:0] a);
    int gap;
    if (send_gaps && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 18);
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    axis_x <= x; axis_y <= y; axis_z <= z; angle <= a;
    pending_matrices.push_back(rotation_of(x, y, z, a));
    do @(posedge clk); while (item_stall);
  endtask

  task automatic go_idle();
    item_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    go_idle();
    while (pending_matrices.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [15:0] rand_angle();
    return 16'($signed($urandom_range(0, 51472)) - 25736);
  endfunction

  // ---- tests ----
  task automatic test_directed();
    send_word(0, 0, 0, 0);
    send_word(0, 0, 0, 25736);             // zero axis ignores angle
    send_word(0, 0, 0, -25736);
    send_word(16'sh7fff, 0, 0, 12868);     // unit axes, ~pi/2
    send_word(0, 16'sh7fff, 0, -12868);
    send_word(0, 0, 16'sh7fff, 25736);     // ~pi
    send_word(16'sh8000, 0, 0, 0);
    send_word(0, 16'sh8000, 0, 25736);
    send_word(0, 0, 16'sh8000, -25736);
    send_word(16'sh8000, 16'sh8000, 16'sh8000, 25735);
    send_word(16'sh7fff, 16'sh7fff, 16'sh7fff, -25735);
    send_word(1, 0, 0, 1);
    send_word(0, 0, -1, -1);
    send_word(1, 1, 1, 8192);
    send_word(-1, 2, -3, 32767);           // beyond pi
    send_word(5, -7, 11, -32768);
    send_word(16'sh5555, 16'shaaaa, 16'sh1234, 16'sh7fff);
    send_word(16'shaaaa, 16'sh5555, 16'shedcb, 16'sh8000);
    send_word(100, 0, 0, 6434);
    send_word(0, -300, 400, -6434);
    drain();
  endtask

  task automatic test_random(int count);
    int kind;
    logic signed [15:0] x, y, z, a;
    repeat (count) begin
      kind = $urandom_range(0, 9);
      x = 16'($urandom); y = 16'($urandom); z = 16'($urandom);
      if (kind == 0) begin
        x = 16'($signed($urandom_range(0, 6)) - 3);
        y = 16'($signed($urandom_range(0, 6)) - 3);
        z = 16'($signed($urandom_range(0, 6)) - 3);
      end else if (kind == 1) begin
        x = 0; y = 0; z = 0;
      end
      a = (kind == 2) ? 16'($urandom) : rand_angle();
      send_word(x, y, z, a);
    end
  endtask

  task automatic test_backpressure();
    // long receiver hold-off while sender keeps offering: pipeline fills
    long_holdoff = 200;
    test_random(120);
    drain();
  endtask

  task automatic test_pause_then_burst();
    test_random(30);
    drain();               // sender waits for every result before going on
    test_random(30);
    drain();
  endtask

  initial begin : main
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    stall_bursts = 1'b1;
    send_gaps = 1'b1;
    test_random(1200);
    test_backpressure();
    test_pause_then_burst();
    stall_bursts = 1'b0;   // closing stretch at full rate
    send_gaps = 1'b0;
    test_random(400);
    drain();
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatch_count == 0 && pending_matrices.size() == 0)
      $display("axis_angle_to_rotation_matrix_tb OK");
    else
      $display("axis_angle_to_rotation_matrix_tb NOT OK");
    $finish;
  end

endmodule
